### src/srpf_pkg.sv
// shared types and constants of the shock response peak filter
`default_nettype none

package srpf_pkg;

    localparam int COEF_W    = 32;
    localparam int RESP_W    = 32;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;

    // input queue between the front and the arithmetic pipeline
    localparam int QUEUE_DEPTH = 4;
    // product, sum, recursion and peak stages
    localparam int BACK_STAGES = 4;

    localparam logic [RESP_W-1:0] RESP_MAX = {1'b0, {(RESP_W-1){1'b1}}};
    localparam logic [RESP_W-1:0] RESP_MIN = {1'b1, {(RESP_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0   = 3'd0,
        CFG_B1   = 3'd1,
        CFG_B2   = 3'd2,
        CFG_A1   = 3'd3,
        CFG_A2   = 3'd4,
        CFG_MODE = 3'd5
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        PEAK_NEG = 2'd0,
        PEAK_ABS = 2'd1,
        PEAK_POS = 2'd2
    } t_peak_mode;

    typedef struct packed {
        logic [COEF_W-1:0] coef_b0;
        logic [COEF_W-1:0] coef_b1;
        logic [COEF_W-1:0] coef_b2;
        logic [COEF_W-1:0] coef_a1;
        logic [COEF_W-1:0] coef_a2;
        logic [MODE_W-1:0] peak_mode;
    } t_coefs;

endpackage

`default_nettype wire

### src/srpf_front.sv
// input side: takes samples, applies record start, builds the sample history
`default_nettype none

module srpf_front #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire logic [SAMPLE_WIDTH-1:0]   i_sample,
    input  wire logic                      i_record_start,
    input  wire logic                      i_q_full,
    output logic                           o_q_wr,
    output logic [3*SAMPLE_WIDTH:0]        o_q_data
);

    logic [SAMPLE_WIDTH-1:0] r_x1;
    logic [SAMPLE_WIDTH-1:0] r_x2;
    logic [SAMPLE_WIDTH-1:0] w_x1;
    logic [SAMPLE_WIDTH-1:0] w_x2;
    logic                    w_accept;

    assign w_accept = i_push && !i_q_full;

    // a new record sees a cleared history
    assign w_x1 = i_record_start ? '0 : r_x1;
    assign w_x2 = i_record_start ? '0 : r_x2;

    assign o_q_wr   = w_accept;
    assign o_q_data = {i_record_start, w_x2, w_x1, i_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
        end else if (w_accept) begin
            r_x1 <= i_sample;
            r_x2 <= w_x1;
        end
    end

endmodule

`default_nettype wire

### src/srpf_fifo.sv
// short queue between the front and the arithmetic pipeline
`default_nettype none

module srpf_fifo #(
    parameter int DATA_W = 73,
    parameter int DEPTH  = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_rd,
    output logic [DATA_W-1:0]      o_rdata,
    output logic                   o_full,
    output logic                   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### src/srpf_back.sv
// arithmetic pipeline: feed-forward products, sum, recursion, saturation and peak
`default_nettype none

module srpf_back #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire srpf_pkg::t_coefs               i_coefs,
    input  wire logic [3*SAMPLE_WIDTH:0]        i_q_data,
    input  wire logic                           i_q_empty,
    output logic                                o_q_rd,
    input  wire logic                           i_pop,
    output logic                                o_empty,
    output logic [srpf_pkg::RESP_W-1:0]         o_response,
    output logic [srpf_pkg::RESP_W-1:0]         o_peak,
    output logic                                o_saturated
);

    localparam int RW     = srpf_pkg::RESP_W;
    localparam int PROD_W = SAMPLE_WIDTH + srpf_pkg::COEF_W;
    localparam int FF_W   = PROD_W + 2;
    localparam int FB_W   = srpf_pkg::COEF_W + RW;
    localparam int ACC_W  = FB_W + 4;
    localparam int SH_W   = ACC_W - COEF_FRAC_BITS;
    localparam int Y_W    = SH_W + 2;
    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    function automatic logic [RW-1:0] f_mag(input logic [RW-1:0] v);
        f_mag = v[RW-1] ? (~v + 1'b1) : v;
    endfunction

    // queue entry
    logic signed [SAMPLE_WIDTH-1:0] q_x;
    logic signed [SAMPLE_WIDTH-1:0] q_x1;
    logic signed [SAMPLE_WIDTH-1:0] q_x2;
    logic                           q_start;

    assign q_x     = $signed(i_q_data[SAMPLE_WIDTH-1:0]);
    assign q_x1    = $signed(i_q_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
    assign q_x2    = $signed(i_q_data[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]);
    assign q_start = i_q_data[3*SAMPLE_WIDTH];

    logic fire_p;
    logic fire_s;
    logic fire_y;
    logic fire_o;

    // product stage
    logic                     r_p_valid;
    logic                     r_p_start;
    logic signed [PROD_W-1:0] r_p_b0;
    logic signed [PROD_W-1:0] r_p_b1;
    logic signed [PROD_W-1:0] r_p_b2;
    logic signed [PROD_W-1:0] w_b0x;
    logic signed [PROD_W-1:0] w_b1x;
    logic signed [PROD_W-1:0] w_b2x;

    // sum stage
    logic                   r_s_valid;
    logic                   r_s_start;
    logic signed [FF_W-1:0] r_s_ff;
    logic signed [FF_W-1:0] w_ff;

    // recursion stage
    logic                   r_y_valid;
    logic                   r_y_start;
    logic [RW-1:0]          r_y_res;
    logic                   r_y_sat;
    logic signed [RW-1:0]   r_y1;
    logic signed [RW-1:0]   r_y2;
    logic signed [FB_W-1:0] r_a2y2;
    logic signed [RW-1:0]   w_y1;
    logic signed [RW-1:0]   w_y2;
    logic signed [FB_W-1:0] w_a2y2;
    logic signed [FB_W-1:0] w_a1y1;
    logic signed [RW-1:0]   w_a2_in;
    logic signed [FB_W-1:0] n_a2y2;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [SH_W-1:0] w_sh;
    logic signed [Y_W-1:0]  w_y;
    logic                   w_fits;
    logic [RW-1:0]          n_res;

    // peak stage
    logic          r_out_valid;
    logic [RW-1:0] r_out_resp;
    logic [RW-1:0] r_out_peak;
    logic          r_out_sat;
    logic [RW-1:0] r_min;
    logic [RW-1:0] r_max;
    logic          r_pk_valid;
    logic          w_pk_keep;
    logic [RW-1:0] n_min;
    logic [RW-1:0] n_max;
    logic [RW-1:0] w_mag_min;
    logic [RW-1:0] w_mag_max;
    logic [RW-1:0] n_peak;

    assign fire_o = r_y_valid && (!r_out_valid || i_pop);
    assign fire_y = r_s_valid && (!r_y_valid || fire_o);
    assign fire_s = r_p_valid && (!r_s_valid || fire_y);
    assign fire_p = !i_q_empty && (!r_p_valid || fire_s);
    assign o_q_rd = fire_p;

    assign w_b0x = $signed(i_coefs.coef_b0) * q_x;
    assign w_b1x = $signed(i_coefs.coef_b1) * q_x1;
    assign w_b2x = $signed(i_coefs.coef_b2) * q_x2;
    assign w_ff  = r_p_b0 + r_p_b1 + r_p_b2;

    // history seen by the item in the recursion stage
    assign w_y1   = r_s_start ? '0 : r_y1;
    assign w_y2   = r_s_start ? '0 : r_y2;
    assign w_a2y2 = r_s_start ? '0 : r_a2y2;
    assign w_a1y1 = $signed(i_coefs.coef_a1) * w_y1;

    // a2 times the response that will be two back for the next item
    assign w_a2_in = fire_y ? w_y1 : r_y2;
    assign n_a2y2  = $signed(i_coefs.coef_a2) * w_a2_in;

    assign w_acc = r_s_ff - w_a1y1 - w_a2y2 + ROUND;
    assign w_sh  = $signed(w_acc[ACC_W-1:COEF_FRAC_BITS]);
    assign w_y   = w_sh + w_y1 + w_y1 - w_y2;

    assign w_fits = (w_y[Y_W-1:RW-1] == '0) || (w_y[Y_W-1:RW-1] == '1);
    assign n_res  = w_fits ? w_y[RW-1:0]
                  : (w_y[Y_W-1] ? srpf_pkg::RESP_MIN : srpf_pkg::RESP_MAX);

    assign w_pk_keep = r_pk_valid && !r_y_start;
    assign n_min = (!w_pk_keep || ($signed(r_y_res) < $signed(r_min))) ? r_y_res : r_min;
    assign n_max = (!w_pk_keep || ($signed(r_y_res) > $signed(r_max))) ? r_y_res : r_max;
    assign w_mag_min = f_mag(n_min);
    assign w_mag_max = f_mag(n_max);

    always_comb begin
        case (i_coefs.peak_mode)
            srpf_pkg::PEAK_NEG: n_peak = w_mag_min;
            srpf_pkg::PEAK_ABS: n_peak = (w_mag_min > w_mag_max) ? w_mag_min : w_mag_max;
            default:            n_peak = w_mag_max;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_s_valid   <= 1'b0;
            r_y_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_y1        <= '0;
            r_y2        <= '0;
            r_a2y2      <= '0;
            r_pk_valid  <= 1'b0;
        end else begin
            if (fire_p) begin
                r_p_valid <= 1'b1;
            end else if (fire_s) begin
                r_p_valid <= 1'b0;
            end
            if (fire_s) begin
                r_s_valid <= 1'b1;
            end else if (fire_y) begin
                r_s_valid <= 1'b0;
            end
            if (fire_y) begin
                r_y_valid <= 1'b1;
            end else if (fire_o) begin
                r_y_valid <= 1'b0;
            end
            if (fire_o) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            r_a2y2 <= n_a2y2;
            if (fire_y) begin
                r_y1 <= $signed(n_res);
                r_y2 <= w_y1;
            end
            if (fire_o) begin
                r_pk_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_p) begin
            r_p_start <= q_start;
            r_p_b0    <= w_b0x;
            r_p_b1    <= w_b1x;
            r_p_b2    <= w_b2x;
        end
        if (fire_s) begin
            r_s_start <= r_p_start;
            r_s_ff    <= w_ff;
        end
        if (fire_y) begin
            r_y_start <= r_s_start;
            r_y_res   <= n_res;
            r_y_sat   <= !w_fits;
        end
        if (fire_o) begin
            r_out_resp <= r_y_res;
            r_out_sat  <= r_y_sat;
            r_out_peak <= n_peak;
            r_min      <= n_min;
            r_max      <= n_max;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_response  = r_out_resp;
    assign o_peak      = r_out_peak;
    assign o_saturated = r_out_sat;

endmodule

`default_nettype wire

### src/shock_response_peak_filter.sv
// shock response spectrum filter channel with record peak tracking
//
// input queue: drive sample and record_start with push; the item is taken at
// a clock edge where push is high and full is low. record_start clears the
// sample and response history and the peak before that sample is used.
// result queue: while empty is low, response, peak and saturated show the
// oldest result; pop at such an edge takes it.
// configuration: i_cfg_index picks b0, b1, b2, a1, a2 or the peak mode,
// i_cfg_data is written when i_cfg_valid is high (o_cfg_ready is always high).
// write only while no item is in flight.
// a taken sample passes the queue, the product stage, the sum stage, the
// recursion stage and the peak stage before its result shows.
// throughput: one item per cycle while pop keeps up; the recursion stage
// closes the loop through one a1 by y1 multiply, the add and the saturation.
// stall: with pop low the pipeline holds, the four entry input queue fills
// and full rises; nothing is dropped.
// reset: history, peak and queues clear; coefficients go to zero and the
// peak mode to absolute peak.
`default_nettype none

module shock_response_peak_filter #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [SAMPLE_WIDTH-1:0]             i_sample,
    input  wire logic                                i_record_start,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [srpf_pkg::RESP_W-1:0]              o_response,
    output logic [srpf_pkg::RESP_W-1:0]              o_peak,
    output logic                                     o_saturated,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [srpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [srpf_pkg::COEF_W-1:0]         i_cfg_data
);

    localparam int Q_W = 3 * SAMPLE_WIDTH + 1;

    srpf_pkg::t_coefs r_coefs;
    logic             q_wr;
    logic [Q_W-1:0]   q_wdata;
    logic             q_rd;
    logic [Q_W-1:0]   q_rdata;
    logic             q_full;
    logic             q_empty;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.coef_b0   <= '0;
            r_coefs.coef_b1   <= '0;
            r_coefs.coef_b2   <= '0;
            r_coefs.coef_a1   <= '0;
            r_coefs.coef_a2   <= '0;
            r_coefs.peak_mode <= srpf_pkg::PEAK_ABS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                srpf_pkg::CFG_B0:   r_coefs.coef_b0   <= i_cfg_data;
                srpf_pkg::CFG_B1:   r_coefs.coef_b1   <= i_cfg_data;
                srpf_pkg::CFG_B2:   r_coefs.coef_b2   <= i_cfg_data;
                srpf_pkg::CFG_A1:   r_coefs.coef_a1   <= i_cfg_data;
                srpf_pkg::CFG_A2:   r_coefs.coef_a2   <= i_cfg_data;
                srpf_pkg::CFG_MODE: r_coefs.peak_mode <= i_cfg_data[srpf_pkg::MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    srpf_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_sample       (i_sample),
        .i_record_start (i_record_start),
        .i_q_full       (q_full),
        .o_q_wr         (q_wr),
        .o_q_data       (q_wdata)
    );

    srpf_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (srpf_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    srpf_back #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coefs     (r_coefs),
        .i_q_data    (q_rdata),
        .i_q_empty   (q_empty),
        .o_q_rd      (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_response  (o_response),
        .o_peak      (o_peak),
        .o_saturated (o_saturated)
    );

endmodule

`default_nettype wire

### src/srpf_checker.sv
// port level checks of the shock response peak filter, bound to the top level
`default_nettype none

module srpf_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        push,
    input wire logic                        full,
    input wire logic                        empty,
    input wire logic                        pop,
    input wire logic [srpf_pkg::RESP_W-1:0] o_response,
    input wire logic                        o_saturated
);

    localparam int CAP   = srpf_pkg::QUEUE_DEPTH + srpf_pkg::BACK_STAGES;
    localparam int CNT_W = $clog2(CAP + 1) + 1;

    // requests taken but not yet delivered
    logic [CNT_W-1:0] r_cnt;
    logic             w_in;
    logic             w_out;

    assign w_in  = push && !full;
    assign w_out = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in && !w_out) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (!w_in && w_out) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_cnt != '0))
        else $error("result shown without an outstanding request");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAP))
        else $error("more requests in flight than the block can hold");

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_saturated) |->
        (o_response == srpf_pkg::RESP_MAX || o_response == srpf_pkg::RESP_MIN))
        else $error("saturated flag on an unclipped response");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_response)))
        else $error("stalled result changed");

endmodule

bind shock_response_peak_filter srpf_checker u_srpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_response  (o_response),
    .o_saturated (o_saturated)
);

`default_nettype wire

### tb/tb_shock_response_peak_filter.sv
// self-checking testbench of the shock response peak filter with a built-in predictor
`timescale 1ns / 100ps

typedef struct packed {
    logic [srpf_pkg::RESP_W-1:0] response;
    logic [srpf_pkg::RESP_W-1:0] peak;
    logic                        saturated;
} t_filter_result;

class peak_filter_scoreboard;
    localparam int SMP_W = 24;
    localparam int FRAC  = 30;
    localparam logic signed [79:0] ROUND_HALF = 80'sd1 <<< (FRAC - 1);

    logic signed [srpf_pkg::COEF_W-1:0] b0, b1, b2, a1, a2;
    logic [srpf_pkg::MODE_W-1:0]        mode;
    logic signed [SMP_W-1:0]            x1, x2;
    logic signed [srpf_pkg::RESP_W-1:0] y1, y2, run_min, run_max;
    bit                                 have_peak;
    t_filter_result                     pending[$];
    int                                 errors;

    function new();
        b0 = '0;
        b1 = '0;
        b2 = '0;
        a1 = '0;
        a2 = '0;
        mode = srpf_pkg::PEAK_ABS;
        x1 = '0;
        x2 = '0;
        y1 = '0;
        y2 = '0;
        run_min = '0;
        run_max = '0;
        have_peak = 0;
        errors = 0;
    endfunction

    function void write_reg(logic [srpf_pkg::CFG_IDX_W-1:0] idx,
                            logic [srpf_pkg::COEF_W-1:0] data);
        case (idx)
            srpf_pkg::CFG_B0:   b0 = data;
            srpf_pkg::CFG_B1:   b1 = data;
            srpf_pkg::CFG_B2:   b2 = data;
            srpf_pkg::CFG_A1:   a1 = data;
            srpf_pkg::CFG_A2:   a2 = data;
            srpf_pkg::CFG_MODE: mode = data[srpf_pkg::MODE_W-1:0];
            default: ;
        endcase
    endfunction

    function void note_input(logic [SMP_W-1:0] smp, logic start);
        logic signed [79:0]                 acc, yw, lim_hi, lim_lo;
        logic signed [SMP_W-1:0]            x;
        logic signed [srpf_pkg::RESP_W-1:0] res;
        logic signed [srpf_pkg::RESP_W:0]   neg_mag, pos_mag;
        t_filter_result                     want;
        x = $signed(smp);
        if (start) begin
            x1 = '0;
            x2 = '0;
            y1 = '0;
            y2 = '0;
            have_peak = 0;
        end
        // all operands are sign-extended to the 80 bit context
        acc = b0 * x + b1 * x1 + b2 * x2 - a1 * y1 - a2 * y2 + ROUND_HALF;
        yw = (acc >>> FRAC) + y1 + y1 - y2;
        lim_hi = $signed(srpf_pkg::RESP_MAX);
        lim_lo = $signed(srpf_pkg::RESP_MIN);
        want.saturated = 1'b0;
        if (yw > lim_hi) begin
            res = srpf_pkg::RESP_MAX;
            want.saturated = 1'b1;
        end else if (yw < lim_lo) begin
            res = srpf_pkg::RESP_MIN;
            want.saturated = 1'b1;
        end else begin
            res = yw[srpf_pkg::RESP_W-1:0];
        end
        x2 = x1;
        x1 = x;
        y2 = y1;
        y1 = res;
        if (!have_peak) begin
            run_min = res;
            run_max = res;
            have_peak = 1;
        end else begin
            if (res < run_min) run_min = res;
            if (res > run_max) run_max = res;
        end
        neg_mag = run_min;
        if (neg_mag < 0) neg_mag = -neg_mag;
        pos_mag = run_max;
        if (pos_mag < 0) pos_mag = -pos_mag;
        case (mode)
            srpf_pkg::PEAK_NEG: want.peak = neg_mag[srpf_pkg::RESP_W-1:0];
            srpf_pkg::PEAK_ABS: want.peak = (neg_mag > pos_mag) ?
                                            neg_mag[srpf_pkg::RESP_W-1:0] :
                                            pos_mag[srpf_pkg::RESP_W-1:0];
            default:            want.peak = pos_mag[srpf_pkg::RESP_W-1:0];
        endcase
        want.response = res;
        pending.push_back(want);
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task check_result(logic [srpf_pkg::RESP_W-1:0] resp, logic [srpf_pkg::RESP_W-1:0] pk,
                      logic sat);
        t_filter_result want;
        if (pending.size() == 0) begin
            report($sformatf("unexpected result, response %h peak %h", resp, pk));
            return;
        end
        want = pending.pop_front();
        if (resp !== want.response)
            report($sformatf("response %h, want %h", resp, want.response));
        if (pk !== want.peak)
            report($sformatf("peak %h, want %h", pk, want.peak));
        if (sat !== want.saturated)
            report($sformatf("saturated %b, want %b", sat, want.saturated));
    endtask
endclass

module tb_shock_response_peak_filter;
    localparam int SMP_W = 24;
    localparam int FRAC  = 30;
    localparam logic [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic [srpf_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [srpf_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [srpf_pkg::MODE_W-1:0] PEAK_SPARE = 2'd3;
    localparam logic [srpf_pkg::COEF_W-1:0] Q_ONE = 32'h4000_0000;
    localparam logic [srpf_pkg::COEF_W-1:0] Q_MINUS_ONE = 32'hC000_0000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [SMP_W-1:0]               i_sample = '0;
    logic                           i_record_start = 1'b0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [srpf_pkg::RESP_W-1:0]    o_response;
    logic [srpf_pkg::RESP_W-1:0]    o_peak;
    logic                           o_saturated;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [srpf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [srpf_pkg::COEF_W-1:0]    i_cfg_data = '0;

    peak_filter_scoreboard sb = new();
    bit push_idle = 0;
    bit pop_idle = 0;
    int pop_hold = 0;

    shock_response_peak_filter #(
        .SAMPLE_WIDTH   (SMP_W),
        .COEF_FRAC_BITS (FRAC)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_sample       (i_sample),
        .i_record_start (i_record_start),
        .empty          (empty),
        .pop            (pop),
        .o_response     (o_response),
        .o_peak         (o_peak),
        .o_saturated    (o_saturated),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SMP_W-1:0] next_sample();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return {SMP_W{r[0]}};
            3, 4, 5: return SMP_W'($signed(r[12:0]));
            default: return r[SMP_W-1:0];
        endcase
    endfunction

    function automatic logic [srpf_pkg::COEF_W-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return Q_ONE;
            4: return Q_MINUS_ONE;
            5: return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // result side: take every result shown, with random stalls on pop
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result(o_response, o_peak, o_saturated);
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else begin
            pop <= 1'b1;
            if (pop_idle && $urandom_range(0, 3) == 0) pop_hold = pick_gap();
        end
    end

    task automatic send_sample(logic [SMP_W-1:0] smp, logic start);
        int gap;
        push <= 1'b1;
        i_sample <= smp;
        i_record_start <= start;
        do @(posedge i_clk); while (full !== 1'b0);
        sb.note_input(smp, start);
        gap = push_idle ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [srpf_pkg::CFG_IDX_W-1:0] idx,
                             logic [srpf_pkg::COEF_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
    endtask

    // reprogram only once the pipeline has emptied
    task automatic program_filter(logic [srpf_pkg::COEF_W-1:0] b0,
                                  logic [srpf_pkg::COEF_W-1:0] b1,
                                  logic [srpf_pkg::COEF_W-1:0] b2,
                                  logic [srpf_pkg::COEF_W-1:0] a1,
                                  logic [srpf_pkg::COEF_W-1:0] a2,
                                  logic [srpf_pkg::MODE_W-1:0] mode);
        logic [srpf_pkg::CFG_IDX_W-1:0] spare;
        push <= 1'b0;
        wait_drain();
        repeat (srpf_pkg::BACK_STAGES + 2) @(posedge i_clk);
        cfg_write(srpf_pkg::CFG_B0, b0);
        cfg_write(srpf_pkg::CFG_B1, b1);
        cfg_write(srpf_pkg::CFG_B2, b2);
        cfg_write(srpf_pkg::CFG_A1, a1);
        cfg_write(srpf_pkg::CFG_A2, a2);
        // upper data bits of the mode write are junk and must be dropped
        cfg_write(srpf_pkg::CFG_MODE,
                  ($urandom() & 32'hFFFF_FFFC) | srpf_pkg::COEF_W'(mode));
        spare = $urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        cfg_write(spare, $urandom());
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random_phase(int n_items, bit hold_mid);
        logic [srpf_pkg::COEF_W-1:0] c [5];
        logic [srpf_pkg::MODE_W-1:0] mode;
        int                          kind;
        int                          damp;
        logic                        start;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            // lightly damped resonator, roots inside the unit circle
            damp = $urandom_range(1 << 16, 1 << 26);
            c[3] = damp + $urandom_range(1 << 18, 1 << 27);
            c[4] = -damp;
            for (int k = 0; k < 3; k++) c[k] = $urandom_range(0, 1 << 27) - (1 << 26);
        end else if (kind < 8) begin
            for (int k = 0; k < 5; k++) c[k] = $urandom();
        end else begin
            for (int k = 0; k < 5; k++) c[k] = pick_extreme();
        end
        mode = srpf_pkg::MODE_W'($urandom_range(0, 3));
        program_filter(c[0], c[1], c[2], c[3], c[4], mode);
        push_idle = $urandom_range(0, 3) != 0;
        pop_idle = $urandom_range(0, 3) != 0;
        for (int i = 0; i < n_items; i++) begin
            if (hold_mid && i == n_items / 2) begin
                push <= 1'b0;
                wait_drain();
            end
            start = (i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 31) == 0);
            send_sample(next_sample(), start);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients, no record start yet
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b0);

        // coefficient extremes drive the recursion into both rails
        program_filter(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, srpf_pkg::PEAK_NEG);
        send_sample(SMP_MAX, 1'b1);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_MAX, 1'b0);
        send_sample('0, 1'b0);
        send_sample({SMP_W{1'b1}}, 1'b0);
        send_sample(24'd1, 1'b0);
        send_sample(SMP_MAX, 1'b0);

        // products of exactly one half lsb check round half up
        program_filter(32'd128, '0, '0, Q_ONE, Q_MINUS_ONE, srpf_pkg::PEAK_POS);
        send_sample(24'sd4194304, 1'b1);
        send_sample(-24'sd4194304, 1'b0);
        send_sample(24'sd4194304, 1'b0);
        send_sample('0, 1'b1);
        send_sample(-24'sd4194304, 1'b0);
        send_sample(24'd1, 1'b0);

        // undefined peak mode behaves as positive peak
        program_filter(Q_ONE, '0, '0, '0, '0, PEAK_SPARE);
        send_sample(-24'sd5, 1'b1);
        send_sample(24'sd3, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_MAX, 1'b0);

        for (int p = 0; p < 10; p++) run_random_phase(45, p == 3);

        push <= 1'b0;
        wait_drain();
        repeat (4 * srpf_pkg::BACK_STAGES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
